FILE: src/running_gcd_of_sequence_assert.svh
// Assertion macros for the running gcd block.
// Used by running_gcd_of_sequence.sv; needs a clock i_clk and reset i_rst_n in scope.
`ifndef RUNNING_GCD_OF_SEQUENCE_ASSERT_SVH
`define RUNNING_GCD_OF_SEQUENCE_ASSERT_SVH

// Checked at every rising edge outside reset.
`define RGCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define RGCD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/rgcd_pkg.sv
// Package for the running gcd block: sequencer step codes, control word type
// and the microcode table. No dependencies.
package rgcd_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef logic [2:0] t_pc;

    localparam t_pc PC_WAIT   = 3'd0;
    localparam t_pc PC_LOAD   = 3'd1;
    localparam t_pc PC_STEP   = 3'd2;
    localparam t_pc PC_FINISH = 3'd3;
    localparam t_pc PC_CHECK  = 3'd4;
    localparam t_pc PC_EMIT   = 3'd5;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_WAIT,
        UOP_LOAD,
        UOP_STEP,
        UOP_FINISH,
        UOP_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        COND_ACCEPT,
        COND_SEEN,
        COND_DONE,
        COND_LAST,
        COND_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_pc   on_true;
        t_pc   on_false;
    } t_uword;

    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_WAIT:   w = '{UOP_WAIT,   COND_ACCEPT,   PC_LOAD,   PC_WAIT};
            PC_LOAD:   w = '{UOP_LOAD,   COND_SEEN,     PC_STEP,   PC_CHECK};
            PC_STEP:   w = '{UOP_STEP,   COND_DONE,     PC_FINISH, PC_STEP};
            PC_FINISH: w = '{UOP_FINISH, COND_LAST,     PC_EMIT,   PC_WAIT};
            PC_CHECK:  w = '{UOP_NOP,    COND_LAST,     PC_EMIT,   PC_WAIT};
            PC_EMIT:   w = '{UOP_EMIT,   COND_OUT_FREE, PC_WAIT,   PC_EMIT};
            default:   w = '{UOP_NOP,    COND_ACCEPT,   PC_WAIT,   PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

FILE: src/running_gcd_of_sequence.sv
// Running gcd of a signed sequence, driven by a microcoded sequencer.
// Depends on rgcd_pkg and running_gcd_of_sequence_assert.svh.
//
//  channel | signals                      | direction
//  input   | i_valid, o_stall, i_value,   | in, transfer when i_valid and !o_stall
//          | i_last                       |
//  output  | o_valid, i_stall, o_divisor  | out, transfer when o_valid and !i_stall
//
// One item is taken at a time. An item is taken in the wait step and then loaded.
// The first element of a sequence then takes a check step; every later element
// runs a binary gcd loop, one step per cycle, and then a finish step.
// A last element then enters an emit step, which waits while the output register
// is held by i_stall; the input stays stalled until then.
// Reset is synchronous and active low and clears the sequence state.
module running_gcd_of_sequence #(
    parameter int DATA_WIDTH = rgcd_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic                         i_last,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_divisor
);
    import rgcd_pkg::*;

    localparam int MW = DATA_WIDTH - 1;
    localparam int KW = $clog2(DATA_WIDTH);

    t_pc             r_pc;
    t_pc             n_pc;
    t_uword          uword;
    logic            cond_hit;

    logic [DATA_WIDTH-1:0] r_value;
    logic                  r_last;
    logic [DATA_WIDTH-1:0] r_first;
    logic [MW-1:0]         r_running;
    logic [1:0]            r_seen;
    logic [MW-1:0]         r_a;
    logic [MW-1:0]         r_b;
    logic [KW-1:0]         r_k;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_divisor;

    logic [DATA_WIDTH-1:0] neg_value;
    logic [MW-1:0]         mag;
    logic                  gcd_done;
    logic                  in_xfer;
    logic                  out_xfer;
    logic                  out_free;
    logic [MW-1:0]         gcd_result;

    assign uword    = ucode_rom(r_pc);
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign gcd_done = (r_a == '0) || (r_b == '0);

    // The most negative value saturates to the largest magnitude.
    assign neg_value = ~r_value + {{(DATA_WIDTH-1){1'b0}}, 1'b1};
    always_comb begin
        if (!r_value[DATA_WIDTH-1]) begin
            mag = r_value[MW-1:0];
        end else if (r_value == {1'b1, {MW{1'b0}}}) begin
            mag = {MW{1'b1}};
        end else begin
            mag = neg_value[MW-1:0];
        end
    end

    assign gcd_result = (r_a | r_b) << r_k;

    always_comb begin
        unique case (uword.cond)
            COND_ACCEPT:   cond_hit = in_xfer;
            COND_SEEN:     cond_hit = (r_seen != 2'd0);
            COND_DONE:     cond_hit = gcd_done;
            COND_LAST:     cond_hit = r_last;
            COND_OUT_FREE: cond_hit = out_free;
            default:       cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_pc = cond_hit ? uword.on_true : uword.on_false;
    end

    always_comb begin
        o_stall = (uword.op != UOP_WAIT);
    end

    assign o_valid   = r_out_valid;
    assign o_divisor = r_divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (uword.op == UOP_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= 2'd0;
            r_running <= '0;
            r_first   <= '0;
        end else begin
            unique case (uword.op)
                UOP_WAIT: begin
                    if (in_xfer) begin
                        r_value <= i_value;
                        r_last  <= i_last;
                    end
                end
                UOP_LOAD: begin
                    if (r_seen == 2'd0) begin
                        r_first   <= r_value;
                        r_running <= mag;
                        r_seen    <= 2'd1;
                    end else begin
                        r_a    <= r_running;
                        r_b    <= mag;
                        r_k    <= '0;
                        r_seen <= 2'd2;
                    end
                end
                UOP_STEP: begin
                    if (!gcd_done) begin
                        priority if (!r_a[0] && !r_b[0]) begin
                            r_a <= r_a >> 1;
                            r_b <= r_b >> 1;
                            r_k <= r_k + {{(KW-1){1'b0}}, 1'b1};
                        end else if (!r_a[0]) begin
                            r_a <= r_a >> 1;
                        end else if (!r_b[0]) begin
                            r_b <= r_b >> 1;
                        end else if (r_a >= r_b) begin
                            r_a <= r_a - r_b;
                        end else begin
                            r_b <= r_b - r_a;
                        end
                    end
                end
                UOP_FINISH: begin
                    r_running <= gcd_result;
                end
                UOP_EMIT: begin
                    if (out_free) begin
                        r_divisor <= (r_seen == 2'd1) ? r_first : {1'b0, r_running};
                        r_seen    <= 2'd0;
                        r_running <= '0;
                        r_first   <= '0;
                    end
                end
                UOP_NOP: begin
                end
                default: begin
                end
            endcase
        end
    end

    `include "running_gcd_of_sequence_assert.svh"

    `RGCD_ASSERT(a_take_then_load,
        in_xfer |=> r_pc == PC_LOAD,
        "transfer not followed by load")
    `RGCD_ASSERT(a_step_shrinks,
        (r_pc == PC_STEP && !gcd_done) |=> (r_a <= $past(r_a) && r_b <= $past(r_b)),
        "gcd operands grew")
    `RGCD_ASSERT(a_emit_holds,
        (r_pc == PC_EMIT && r_out_valid && i_stall) |=> r_pc == PC_EMIT,
        "emit overran a held result")
    `RGCD_ASSERT_ALWAYS(a_emit_seen,
        (i_rst_n && r_pc == PC_EMIT) |-> r_seen != 2'd0,
        "emit with empty sequence")

endmodule

FILE: tb/tb_running_gcd_of_sequence.sv
// Testbench for running_gcd_of_sequence: drives signed sequences with a last flag and
// checks every divisor against a built-in running gcd predictor, under varied idle
// and stall patterns. Depends only on the block's RTL and its package.
module tb_running_gcd_of_sequence;

    localparam int DW = 32;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic signed [DW-1:0] i_value = '0;
    logic                 i_last  = 1'b0;
    logic                 i_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic signed [DW-1:0] o_divisor;

    logic signed [DW-1:0] expected_divisors[$];
    logic [DW-2:0]        gcd_acc    = '0;
    logic signed [DW-1:0] first_word = '0;
    logic [1:0]           elems_seen = '0;

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_len       = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int sequences_sent = 0;
    int results_seen   = 0;
    int error_count    = 0;

    running_gcd_of_sequence #(.DATA_WIDTH(DW)) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_value   (i_value),
        .i_last    (i_last),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_divisor (o_divisor)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [DW-2:0] abs_saturated(input logic signed [DW-1:0] elem);
        logic [DW-1:0] neg;
        if (!elem[DW-1]) return elem[DW-2:0];
        neg = -elem;
        if (neg[DW-1]) return '1;
        return neg[DW-2:0];
    endfunction

    function automatic logic [DW-2:0] euclid_gcd(input logic [DW-2:0] a, input logic [DW-2:0] b);
        logic [DW-2:0] rem;
        while (a != '0) begin
            rem = b % a;
            b = a;
            a = rem;
        end
        return b;
    endfunction

    task automatic add_expected(input logic signed [DW-1:0] div);
        expected_divisors = {expected_divisors, div};
    endtask

    task automatic fold_element(input logic signed [DW-1:0] elem, input logic is_last);
        logic [DW-2:0] mag;
        mag = abs_saturated(elem);
        if (elems_seen == 2'd0) begin
            first_word = elem;
            gcd_acc    = mag;
            elems_seen = 2'd1;
        end else begin
            gcd_acc    = euclid_gcd(gcd_acc, mag);
            elems_seen = 2'd2;
        end
        if (is_last) begin
            if (elems_seen == 2'd1) begin
                add_expected(first_word);
            end else begin
                add_expected({1'b0, gcd_acc});
            end
            gcd_acc    = '0;
            first_word = '0;
            elems_seen = '0;
            sequences_sent++;
        end
    endtask

    function automatic logic signed [DW-1:0] pick_value(input int unsigned factor);
        logic signed [DW-1:0] v;
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = 32'sh7FFFFFFF;
            2:       v = 32'sh80000001;
            3, 4:    v = $urandom();
            default: v = factor * $urandom_range(0, 32'h7FFFFFFF / factor);
        endcase
        if ($urandom_range(1)) v = -v;
        if (v == 32'sh80000000) v = 32'sh80000001;
        return v;
    endfunction

    task automatic send_item(input logic signed [DW-1:0] elem, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= elem;
        i_last  <= is_last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        fold_element(elem, is_last);
        items_sent++;
    endtask

    task automatic send_random_sequence();
        int unsigned len;
        int unsigned factor;
        len = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        factor = $urandom_range(1) ? $urandom_range(1, 1500) : (1 << $urandom_range(0, 20));
        for (int k = 0; k < len; k++) send_item(pick_value(factor), k == len - 1);
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_divisors.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_item(32'sh7FFFFFFF, 1'b1);
        send_item(32'sh80000001, 1'b1);
        send_item(32'sd0, 1'b1);
        send_item(-32'sd1, 1'b1);
        send_item(32'sd1, 1'b1);
        send_item(32'sd0, 1'b0);
        send_item(32'sd0, 1'b1);
        send_item(-32'sd12, 1'b0);
        send_item(32'sd18, 1'b1);
        send_item(32'sh7FFFFFFF, 1'b0);
        send_item(32'sh80000001, 1'b1);
        send_item(32'sd0, 1'b0);
        send_item(-32'sd5, 1'b1);
        send_item(32'sd1, 1'b0);
        send_item(32'sh7FFFFFFF, 1'b1);
        send_item(32'sh40000000, 1'b0);
        send_item(-32'sh00100000, 1'b1);
        send_item(32'sd12, 1'b0);
        send_item(-32'sd18, 1'b0);
        send_item(32'sd30, 1'b1);
        send_item(32'sd91, 1'b0);
        send_item(-32'sd77, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(32'sd35, 1'b1);
        wait_results_done();
    endtask

    task automatic test_random_traffic();
        int idle_mix[4]  = '{0, 55, 0, 34};
        int stall_mix[4] = '{0, 0, 55, 34};
        int phase_base;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_mix[p];
            stall_pct     = stall_mix[p];
            phase_base    = items_sent;
            while (items_sent - phase_base < 90) send_random_sequence();
            wait_results_done();
        end
    endtask

    // The output is held off long enough that the block stops taking input.
    task automatic test_output_hold();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_len      = 400;
        send_item(pick_value(1), 1'b1);
        repeat (8) send_random_sequence();
        wait_results_done();
    endtask

    always @(posedge i_clk) begin
        if (hold_len != 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        logic signed [DW-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_divisors.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected divisor %0d at %0t", o_divisor, $time);
                end
            end else begin
                want = expected_divisors.pop_front();
                if (o_divisor !== want) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("divisor mismatch at %0t: expected %0d, got %0d",
                                 $time, want, o_divisor);
                    end
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic();
        test_output_hold();
        stall_pct = 0;
        wait_results_done();
        repeat (2 * DW + 8) @(posedge i_clk);
        $display("Sent %0d elements in %0d sequences and checked %0d divisors,",
                 items_sent, sequences_sent, results_seen);
        $display("covering edge values, four idle and stall mixes and a long output hold.");
        if (error_count == 0) begin
            $display("tb_running_gcd_of_sequence: clean");
        end else begin
            $display("tb_running_gcd_of_sequence: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d divisors still expected.", expected_divisors.size());
        $display("tb_running_gcd_of_sequence: errors");
        $finish;
    end

endmodule
